### hw/rtl/ring_buffer_with_overwrite_macros.svh
// Assertion macros for the ring buffer RTL.
// Both macros expect clk and rst_n in scope.
`ifndef RING_BUFFER_WITH_OVERWRITE_MACROS_SVH
`define RING_BUFFER_WITH_OVERWRITE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RBO_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RBO_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RBO_ASSERT(label, prop, msg)
`define RBO_NEVER(label, cond, msg)
`endif

`endif

### hw/rtl/rbo_pkg.sv
package rbo_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int VAL_W   = 32;
    localparam int IDX_W   = 4;
    localparam int OP_W    = 2;
    localparam int CAP_W   = 5;
    localparam int S_DATA_W = 40;  // value + index, padded to bytes
    localparam int M_DATA_W = 40;  // read_value + 3 flags, padded to bytes

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_TAKE  = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic {
        CFG_CAPACITY = 1'b0,
        CFG_NO_OVW   = 1'b1
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MOD   = 5'b00010,
        ST_READ  = 5'b00100,
        ST_SWEEP = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

### hw/rtl/ring_buffer_with_overwrite.sv
// Channel   Dir  Fields (low bit up)                               Transfer
// s_*       in   tdata: value[31:0] index[35:32], tuser: op[1:0]   tvalid & tready
// m_*       out  tdata: read_value[31:0] ok[32] is_full[33]
//                      is_empty[34]                                tvalid & tready
// cfg_*     in   index 0 capacity, 1 no_overwrite                  cfg_we
//
// Add, peek and a take from a non-empty buffer each run MW = max(clog2(DEPTH), 4) + 1
// bit-serial modulo steps in the shared compare/subtract remainder unit; clear zeroes
// the first capacity words; refused items and capacity 0 go straight to the result.
// After reset the store is zeroed by a sweep of all DEPTH words; s_tready is low.
// A result waits in the output register; the next item finishes only when it drains.
`include "ring_buffer_with_overwrite_macros.svh"

module ring_buffer_with_overwrite #(
    parameter int DEPTH     = rbo_pkg::DEPTH_DEF,
    parameter int WORD_BITS = rbo_pkg::WORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rbo_pkg::S_DATA_W-1:0] s_tdata,   // value[31:0], index[35:32]
    input  logic [rbo_pkg::OP_W-1:0]     s_tuser,   // op[1:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rbo_pkg::M_DATA_W-1:0] m_tdata,   // read_value, ok, is_full, is_empty
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [rbo_pkg::CAP_W-1:0]    cfg_data
);
    import rbo_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW = ((PW > IDX_W) ? PW : IDX_W) + 1;
    localparam int CW = $clog2(MW);

    logic [WORD_BITS-1:0] mem [DEPTH];

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [CAP_W-1:0]     capacity_reg;
    logic                 no_ovw_reg;
    logic [CAP_W-1:0]     cap_reg, cap_next;
    logic [PW-1:0]        head_reg, head_next;
    logic [PW-1:0]        tail_reg, tail_next;
    logic                 full_reg, full_next;
    logic [MW-1:0]        num_reg, num_next;
    logic [CAP_W-1:0]     rem_reg, rem_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [PW-1:0]        sweep_reg, sweep_next;
    logic [PW-1:0]        sweep_last_reg, sweep_last_next;
    logic                 boot_reg, boot_next;
    logic                 ok_reg, ok_next;
    logic [VAL_W-1:0]     rdv_reg, rdv_next;
    logic                 out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]     out_val_reg, out_val_next;
    logic                 out_ok_reg, out_ok_next;
    logic                 out_full_reg, out_full_next;
    logic                 out_empty_reg, out_empty_next;
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [CAP_W-1:0]     cap_eff;
    logic                 accept;
    op_t                  in_op;
    logic [VAL_W-1:0]     in_val;
    logic [IDX_W-1:0]     in_idx;
    logic [CAP_W:0]       rem_shift;
    logic [CAP_W:0]       rem_sub;
    logic [CAP_W-1:0]     rem_step;
    logic [PW-1:0]        mod_ptr;
    logic [63:0]          rd_wide;
    logic [PW-1:0]        rd_addr;
    logic                 wr_en;
    logic [PW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    assign cap_eff  = (32'(capacity_reg) > DEPTH) ? CAP_W'(DEPTH) : capacity_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_op    = op_t'(s_tuser);
    assign in_val   = s_tdata[VAL_W-1:0];
    assign in_idx   = s_tdata[VAL_W+IDX_W-1:VAL_W];

    // one restoring remainder step per cycle, numerator MSB first
    assign rem_shift = {rem_reg, num_reg[MW-1]};
    assign rem_sub   = rem_shift - {1'b0, cap_reg};
    assign rem_step  = (rem_shift >= {1'b0, cap_reg}) ? rem_sub[CAP_W-1:0]
                                                      : rem_shift[CAP_W-1:0];
    assign mod_ptr   = PW'(rem_step);
    assign rd_wide   = 64'(rd_data_reg);
    assign rd_addr   = (state_reg == ST_MOD) ? mod_ptr : head_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - VAL_W - 3){1'b0}},
                       out_empty_reg, out_full_reg, out_ok_reg, out_val_reg};

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        cap_next        = cap_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        full_next       = full_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        sweep_next      = sweep_reg;
        sweep_last_next = sweep_last_reg;
        boot_next       = boot_reg;
        ok_next         = ok_reg;
        rdv_next        = rdv_reg;
        out_val_next    = out_val_reg;
        out_ok_next     = out_ok_reg;
        out_full_next   = out_full_reg;
        out_empty_next  = out_empty_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        wr_en           = 1'b0;
        wr_addr         = tail_reg;
        wr_data         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next  = in_op;
                    cap_next = cap_eff;
                    ok_next  = 1'b0;
                    rdv_next = '0;
                    rem_next = '0;
                    cnt_next = CW'(MW - 1);
                    if (cap_eff == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        case (in_op)
                            OP_ADD:
                            begin
                                if (full_reg && no_ovw_reg)
                                begin
                                    state_next = ST_DONE;
                                end
                                else
                                begin
                                    wr_en      = 1'b1;
                                    wr_addr    = tail_reg;
                                    wr_data    = WORD_BITS'(in_val);
                                    num_next   = MW'(tail_reg) + MW'(1);
                                    ok_next    = 1'b1;
                                    state_next = ST_MOD;
                                end
                            end
                            OP_TAKE:
                            begin
                                state_next = ST_READ;
                            end
                            OP_PEEK:
                            begin
                                num_next   = MW'(head_reg) + MW'(in_idx);
                                ok_next    = 1'b1;
                                state_next = ST_MOD;
                            end
                            default:
                            begin
                                head_next       = '0;
                                tail_next       = '0;
                                full_next       = 1'b0;
                                sweep_next      = '0;
                                sweep_last_next = PW'(cap_eff - CAP_W'(1));
                                ok_next         = 1'b1;
                                state_next      = ST_SWEEP;
                            end
                        endcase
                    end
                end
            end
            ST_MOD:
            begin
                num_next = num_reg << 1;
                rem_next = rem_step;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    case (op_reg)
                        OP_ADD:
                        begin
                            // full implies head == tail, so both move together
                            tail_next = mod_ptr;
                            if (full_reg)
                                head_next = mod_ptr;
                            else if (mod_ptr == head_reg)
                                full_next = 1'b1;
                            state_next = ST_DONE;
                        end
                        OP_TAKE:
                        begin
                            head_next  = mod_ptr;
                            state_next = ST_DONE;
                        end
                        OP_PEEK:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                rdv_next = rd_wide[VAL_W-1:0];
                if (op_reg == OP_TAKE && (full_reg || head_reg != tail_reg))
                begin
                    wr_en      = 1'b1;
                    wr_addr    = head_reg;
                    wr_data    = '0;
                    ok_next    = 1'b1;
                    full_next  = 1'b0;
                    num_next   = MW'(head_reg) + MW'(1);
                    rem_next   = '0;
                    cnt_next   = CW'(MW - 1);
                    state_next = ST_MOD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SWEEP:
            begin
                wr_en   = 1'b1;
                wr_addr = sweep_reg;
                wr_data = '0;
                if (sweep_reg == sweep_last_reg)
                begin
                    boot_next  = 1'b0;
                    state_next = boot_reg ? ST_IDLE : ST_DONE;
                end
                else
                begin
                    sweep_next = sweep_reg + PW'(1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = rdv_reg;
                    out_ok_next    = ok_reg;
                    out_full_next  = full_reg;
                    out_empty_next = !full_reg && (head_reg == tail_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            op_reg         <= OP_ADD;
            capacity_reg   <= CAP_RESET;
            no_ovw_reg     <= 1'b0;
            cap_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            full_reg       <= 1'b0;
            cnt_reg        <= '0;
            sweep_reg      <= '0;
            sweep_last_reg <= PW'(DEPTH - 1);
            boot_reg       <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            cap_reg        <= cap_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            full_reg       <= full_next;
            cnt_reg        <= cnt_next;
            sweep_reg      <= sweep_next;
            sweep_last_reg <= sweep_last_next;
            boot_reg       <= boot_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CAPACITY: capacity_reg <= cfg_data;
                    CFG_NO_OVW:   no_ovw_reg   <= cfg_data[0];
                    default:      no_ovw_reg   <= no_ovw_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        ok_reg        <= ok_next;
        rdv_reg       <= rdv_next;
        out_val_reg   <= out_val_next;
        out_ok_reg    <= out_ok_next;
        out_full_reg  <= out_full_next;
        out_empty_reg <= out_empty_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    `RBO_ASSERT(a_full_ptrs, full_reg |-> (head_reg == tail_reg), "full with head != tail")
    `RBO_ASSERT(a_rem_bound, (state_reg == ST_MOD) |-> (rem_reg < cap_reg), "remainder >= capacity")
    `RBO_ASSERT(a_accept_busy, accept |=> (state_reg != ST_IDLE), "accepted item not started")
    `RBO_NEVER(a_done_no_write, (state_reg == ST_DONE) && wr_en, "store write while finishing")

endmodule
